/* hdl/tcce_pkg.sv */
package tcce_pkg;

	localparam int CELL_PIXELS = 8;
	localparam int CELL_SHIFT  = 3;
	localparam int TAB_STEP    = 4;
	localparam int QDEPTH      = 2;

	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam logic CMD_PUT = 1'b0;
	localparam logic CMD_POS = 1'b1;

	localparam logic [1:0] REG_FG   = 2'd0;
	localparam logic [1:0] REG_BG   = 2'd1;
	localparam logic [1:0] REG_DISP = 2'd2;

	localparam logic [31:0] FG_RESET = 32'hFFFF_FFFF;
	localparam logic [31:0] BG_RESET = 32'hFF00_0000;

	typedef enum logic [1:0] {
		ACT_ECHO   = 2'd0,
		ACT_DRAW   = 2'd1,
		ACT_SCROLL = 2'd2,
		ACT_POS    = 2'd3
	} action_t;

	typedef enum logic {
		PH_FIRST,
		PH_SCROLL
	} phase_t;

	// one decoded request, handed from front to back
	typedef struct packed {
		action_t     action;
		logic [7:0]  glyph;
		logic [9:0]  pixel_x;
		logic [9:0]  pixel_y;
		logic [31:0] color;
		logic [7:0]  echo_char;
		logic        echo_valid;
		logic [6:0]  cursor_col;
		logic [6:0]  cursor_row;
		logic        scroll;
	} rec_t;

endpackage

/* hdl/tcce_front.sv */
module tcce_front #(
	parameter int COLS = 128,
	parameter int ROWS = 96
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_addr,
	input  logic [31:0]       cfg_data,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [23:0]       s_tdata,
	input  logic [0:0]        s_tuser,
	input  logic              q_full,
	output logic              push,
	output tcce_pkg::rec_t    push_rec,
	output logic [31:0]       bg_color
);
	import tcce_pkg::*;

	localparam logic [7:0] COLS_W  = 8'(COLS);
	localparam logic [7:0] ROWS_W  = 8'(ROWS);
	localparam logic [6:0] COLS_M1 = 7'(COLS - 1);
	localparam logic [6:0] ROWS_M1 = 7'(ROWS - 1);
	localparam logic [7:0] TAB_MASK = ~8'(TAB_STEP - 1);

	logic [31:0] fg_color_q, bg_color_q;
	logic        disp_q;
	logic [6:0]  col_q, row_q;

	logic        cmd;
	logic [7:0]  ch;
	logic [6:0]  nc, nr;
	logic [7:0]  col_n, row_n, tab_col, inc_col;
	logic [6:0]  draw_col, draw_row;
	logic [6:0]  col_o, row_o;
	logic        draw, scroll;
	logic [7:0]  gl;
	logic [31:0] colr;
	rec_t        rec;

	assign cmd = s_tuser[0];
	assign ch  = s_tdata[7:0];
	assign nc  = s_tdata[14:8];
	assign nr  = s_tdata[21:15];

	assign s_tready = !q_full;
	assign push     = s_tvalid && s_tready;
	assign bg_color = bg_color_q;

	assign tab_col = ({1'b0, col_q} + 8'(TAB_STEP)) & TAB_MASK;
	assign inc_col = {1'b0, col_q} + 8'd1;

	always_comb begin
		col_n    = {1'b0, col_q};
		row_n    = {1'b0, row_q};
		draw     = 1'b0;
		gl       = 8'd0;
		draw_col = col_q;
		draw_row = row_q;
		colr     = 32'd0;
		unique case (ch)
			CH_LF: begin
				col_n = 8'd0;
				row_n = {1'b0, row_q} + 8'd1;
			end
			CH_CR: begin
				col_n = 8'd0;
			end
			CH_TAB: begin
				if (tab_col >= COLS_W) begin
					col_n = 8'd0;
					row_n = {1'b0, row_q} + 8'd1;
				end else begin
					col_n = tab_col;
				end
			end
			CH_BS: begin
				if (col_q != 7'd0) begin
					col_n = {1'b0, col_q} - 8'd1;
				end else if (row_q != 7'd0) begin
					col_n = {1'b0, COLS_M1};
					row_n = {1'b0, row_q} - 8'd1;
				end
				draw     = 1'b1;
				gl       = CH_SPACE;
				draw_col = col_n[6:0];
				draw_row = row_n[6:0];
				colr     = bg_color_q;
			end
			default: begin
				draw = 1'b1;
				gl   = ch;
				colr = fg_color_q;
				if (inc_col >= COLS_W) begin
					col_n = 8'd0;
					row_n = {1'b0, row_q} + 8'd1;
				end else begin
					col_n = inc_col;
				end
			end
		endcase
		scroll = (row_n >= ROWS_W);
		col_o  = col_n[6:0];
		row_o  = scroll ? ROWS_M1 : row_n[6:0];
	end

	always_comb begin
		rec = '0;
		if (cmd == CMD_POS) begin
			rec.action     = ACT_POS;
			rec.cursor_col = (nc > COLS_M1) ? COLS_M1 : nc;
			rec.cursor_row = (nr > ROWS_M1) ? ROWS_M1 : nr;
		end else if (!disp_q) begin
			rec.action     = ACT_ECHO;
			rec.echo_char  = ch;
			rec.echo_valid = 1'b1;
			rec.cursor_col = col_q;
			rec.cursor_row = row_q;
		end else begin
			rec.action     = draw ? ACT_DRAW : ACT_ECHO;
			rec.glyph      = gl;
			rec.pixel_x    = draw ? {draw_col, 3'b000} : 10'd0;
			rec.pixel_y    = draw ? {draw_row, 3'b000} : 10'd0;
			rec.color      = colr;
			rec.echo_char  = ch;
			rec.echo_valid = 1'b1;
			rec.cursor_col = col_o;
			rec.cursor_row = row_o;
			rec.scroll     = scroll;
		end
	end

	assign push_rec = rec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_color_q <= FG_RESET;
			bg_color_q <= BG_RESET;
			disp_q     <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_FG:   fg_color_q <= cfg_data;
				REG_BG:   bg_color_q <= cfg_data;
				REG_DISP: disp_q     <= cfg_data[0];
				default:  ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= 7'd0;
			row_q <= 7'd0;
		end else if (push) begin
			col_q <= rec.cursor_col;
			row_q <= rec.cursor_row;
		end
	end

	// cursor never leaves the grid
	a_cursor_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, col_q} < COLS_W) && ({1'b0, row_q} < ROWS_W))
		else $error("cursor outside grid");

endmodule

/* hdl/tcce_queue.sv */
module tcce_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  tcce_pkg::rec_t  push_rec,
	output logic            full,
	input  logic            pop,
	output logic            q_valid,
	output tcce_pkg::rec_t  q_rec
);
	import tcce_pkg::*;

	localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CNT_W = $clog2(QDEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QDEPTH);
	localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(QDEPTH - 1);

	rec_t             mem_q [QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign full    = (cnt_q == DEPTH_C);
	assign q_valid = (cnt_q != '0);
	assign q_rec   = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && q_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_P) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_P) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= DEPTH_C)
		else $error("queue count overflow");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("request pushed into full queue");

endmodule

/* hdl/tcce_back.sv */
module tcce_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  tcce_pkg::rec_t  q_rec,
	output logic            pop,
	input  logic [31:0]     bg_color,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [87:0]     m_tdata,
	output logic [1:0]      m_tuser,
	output logic            m_tlast
);
	import tcce_pkg::*;

	phase_t      phase_q, phase_n;
	logic        load, sel_scroll;
	logic        m_tvalid_q;
	action_t     action_q;
	logic [7:0]  glyph_q, echo_q;
	logic [9:0]  px_q, py_q;
	logic [31:0] color_q;
	logic        ev_q, last_q;
	logic [6:0]  col_q, row_q;

	// output register free or draining this cycle
	assign load = !m_tvalid_q || m_tready;

	always_comb begin
		phase_n = phase_q;
		unique case (phase_q)
			PH_FIRST:  if (load && q_valid && q_rec.scroll) phase_n = PH_SCROLL;
			PH_SCROLL: if (load) phase_n = PH_FIRST;
			default:   phase_n = PH_FIRST;
		endcase
	end

	always_comb begin
		pop        = 1'b0;
		sel_scroll = 1'b0;
		unique case (phase_q)
			PH_FIRST:  pop = load && q_valid;
			PH_SCROLL: sel_scroll = load;
			default:   ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_FIRST;
			m_tvalid_q <= 1'b0;
		end else begin
			phase_q <= phase_n;
			if (load) begin
				m_tvalid_q <= pop || sel_scroll;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			action_q <= q_rec.action;
			glyph_q  <= q_rec.glyph;
			px_q     <= q_rec.pixel_x;
			py_q     <= q_rec.pixel_y;
			color_q  <= q_rec.color;
			echo_q   <= q_rec.echo_char;
			ev_q     <= q_rec.echo_valid;
			col_q    <= q_rec.cursor_col;
			row_q    <= q_rec.cursor_row;
			last_q   <= !q_rec.scroll;
		end else if (sel_scroll) begin
			// cursor fields kept from the first result
			action_q <= ACT_SCROLL;
			glyph_q  <= 8'd0;
			px_q     <= 10'd0;
			py_q     <= 10'd0;
			color_q  <= bg_color;
			echo_q   <= 8'd0;
			ev_q     <= 1'b0;
			last_q   <= 1'b1;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = action_q;
	assign m_tlast  = last_q;
	assign m_tdata  = {5'd0, row_q, col_q, ev_q, echo_q, color_q, py_q, px_q, glyph_q};

	a_scroll_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_SCROLL) |-> (m_tvalid_q && !last_q))
		else $error("scroll pending without open first result");

	a_scroll_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_SCROLL && load) |=> (m_tvalid_q && action_q == ACT_SCROLL && last_q))
		else $error("scroll result not issued");

endmodule

/* hdl/text_console_cursor_engine_core.sv */
// Text console cursor engine.
// Input stream s_*: one request per beat. s_tuser[0] = cmd (0 put char, 1 set
// position). s_tdata = char_code[7:0], new_col[14:8], new_row[21:15].
// Output stream m_*: one or two results per request; m_tlast marks the final
// one. m_tuser = action. A put char with the display enabled that runs past
// the last row gives a draw/echo result followed by a scroll result.
// Config: cfg_we writes cfg_data into register cfg_addr (0 fg_color,
// 1 bg_color, 2 display_enabled); write only while the block is idle.
// Accepted requests pass the queue and then the output register to m_*.
// Throughput: one request per cycle while m_tready stays high; a scroll
// result stalls the queue. The front decodes combinationally, updates the
// cursor on accept and pushes into a 2-entry queue drained by the back.
// m_tready low fills the queue, then s_tready drops; no result is lost.
// Reset (arst_n low) clears the cursor to 0,0, empties the queue and restores
// register defaults.
module text_console_cursor_engine_core #(
	parameter int COLS = 128,
	parameter int ROWS = 96
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [31:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // char_code[7:0], new_col[14:8], new_row[21:15]
	input  logic [0:0]  s_tuser,   // cmd[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	// glyph[7:0], pixel_x[17:8], pixel_y[27:18], color[59:28], echo_char[67:60],
	// echo_valid[68], cursor_col[75:69], cursor_row[82:76]
	output logic [87:0] m_tdata,
	output logic [1:0]  m_tuser,   // action[1:0]
	output logic        m_tlast
);
	import tcce_pkg::*;

	logic        q_full, push, q_valid, pop;
	rec_t        push_rec, q_rec;
	logic [31:0] bg_color;

	tcce_front #(
		.COLS(COLS),
		.ROWS(ROWS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.push     (push),
		.push_rec (push_rec),
		.bg_color (bg_color)
	);

	tcce_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.full     (q_full),
		.pop      (pop),
		.q_valid  (q_valid),
		.q_rec    (q_rec)
	);

	tcce_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_rec    (q_rec),
		.pop      (pop),
		.bg_color (bg_color),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
